@@ rtl/rx_sync_hop_controller_unit_assert.svh @@
// Assertion macros shared by the RTL. Empty when SYNTH is defined.
`ifndef RX_SYNC_HOP_CONTROLLER_UNIT_ASSERT_SVH
`define RX_SYNC_HOP_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTH
// implication checked every clock outside reset
`define RSHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// plain check, no reset gating
`define RSHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/rshc_pkg.sv @@
package rshc_pkg;

    localparam int PERIOD_W     = 24;
    localparam int LOSS_W       = 8;
    localparam int CNT_W        = 5;
    localparam int HOP_W        = 4;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int MAX_CHANNELS = 16;
    localparam int HOP_SLOTS    = 2 ** HOP_W;

    // effective hop table limit
    localparam logic [CNT_W-1:0] HOP_CAP =
        CNT_W'((MAX_CHANNELS < HOP_SLOTS) ? MAX_CHANNELS : HOP_SLOTS);

    localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

    // event codes
    localparam logic [MODE_W-1:0] EVT_TICK = 2'd0;
    localparam logic [MODE_W-1:0] EVT_PKT  = 2'd1;
    localparam logic [MODE_W-1:0] EVT_SCAN = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AFTER_ACK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT     = 3'd5;

    // config reset values
    localparam logic [PERIOD_W-1:0] RST_SEARCH_PERIOD  = 24'd32768;
    localparam logic [PERIOD_W-1:0] RST_OPERATE_PERIOD = 24'd3277;
    localparam logic [PERIOD_W-1:0] RST_AFTER_ACK      = 24'd3000;
    localparam logic [PERIOD_W-1:0] RST_ACK_WAIT       = 24'd300;
    localparam logic [LOSS_W-1:0]   RST_LOSS_THRESH    = 8'd3;
    localparam logic [CNT_W-1:0]    RST_CHAN_COUNT     = 5'd3;

    typedef enum logic [1:0] {
        LINK_SEARCH   = 2'd0,
        LINK_WAIT_ACK = 2'd1,
        LINK_OPERATE  = 2'd2
    } t_link;

    typedef struct packed {
        logic [PERIOD_W-1:0] search_period;
        logic [PERIOD_W-1:0] operate_period;
        logic [PERIOD_W-1:0] after_ack_period;
        logic [PERIOD_W-1:0] ack_wait_period;
        logic [LOSS_W-1:0]   loss_threshold;
        logic [CNT_W-1:0]    channel_count;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              payload_ok;
    } t_evt_word;

    typedef struct packed {
        logic                rx_enable;
        logic [HOP_W-1:0]    channel_index;
        logic                channel_set;
        logic [PERIOD_W-1:0] timer_period;
        logic                timer_restart;
        logic                reply_sent;
        logic [1:0]          link_state;
        logic [LOSS_W-1:0]   loss_count;
    } t_res_word;

    // next hop index, wrapping at the effective channel count
    function automatic logic [HOP_W-1:0] next_hop(
        input logic [HOP_W-1:0] idx,
        input logic [CNT_W-1:0] cnt
    );
        logic [CNT_W-1:0] lim;
        logic [CNT_W-1:0] nxt;
        lim = (cnt > HOP_CAP) ? HOP_CAP : cnt;
        if (lim == '0) begin
            lim = CNT_W'(1);
        end
        nxt = CNT_W'(idx) + CNT_W'(1);
        return (nxt >= lim) ? '0 : nxt[HOP_W-1:0];
    endfunction

endpackage

@@ rtl/rshc_chan_if.sv @@
interface rshc_evt_if import rshc_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              payload_ok;

    modport source (output valid, output mode, output payload_ok, input ready);
    modport sink   (input valid, input mode, input payload_ok, output ready);
endinterface

interface rshc_res_if import rshc_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                rx_enable;
    logic [HOP_W-1:0]    channel_index;
    logic                channel_set;
    logic [PERIOD_W-1:0] timer_period;
    logic                timer_restart;
    logic                reply_sent;
    logic [1:0]          link_state;
    logic [LOSS_W-1:0]   loss_count;

    modport source (
        output valid, output rx_enable, output channel_index, output channel_set,
        output timer_period, output timer_restart, output reply_sent,
        output link_state, output loss_count, input ready
    );
    modport sink (
        input valid, input rx_enable, input channel_index, input channel_set,
        input timer_period, input timer_restart, input reply_sent,
        input link_state, input loss_count, output ready
    );
endinterface

@@ rtl/rshc_cfg_regs.sv @@
module rshc_cfg_regs import rshc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.search_period    <= RST_SEARCH_PERIOD;
            r_cfg.operate_period   <= RST_OPERATE_PERIOD;
            r_cfg.after_ack_period <= RST_AFTER_ACK;
            r_cfg.ack_wait_period  <= RST_ACK_WAIT;
            r_cfg.loss_threshold   <= RST_LOSS_THRESH;
            r_cfg.channel_count    <= RST_CHAN_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEARCH_PERIOD:  r_cfg.search_period    <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_OPERATE_PERIOD: r_cfg.operate_period   <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_AFTER_ACK:      r_cfg.after_ack_period <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_ACK_WAIT:       r_cfg.ack_wait_period  <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_LOSS_THRESH:    r_cfg.loss_threshold   <= i_cfg_wdata[LOSS_W-1:0];
                CFG_CHAN_COUNT:     r_cfg.channel_count    <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/rshc_link_fsm.sv @@
`include "rx_sync_hop_controller_unit_assert.svh"

module rshc_link_fsm import rshc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_go,
    input  t_evt_word i_evt,
    output t_res_word o_res
);

    t_link               r_link, n_link;
    logic                r_rx_on, n_rx_on;
    logic                r_reload, n_reload;
    logic                r_first, n_first;
    logic                r_got, n_got;
    logic [HOP_W-1:0]    r_hop, n_hop;
    logic [LOSS_W-1:0]   r_missed, n_missed;
    logic [PERIOD_W-1:0] r_period, n_period;

    logic [HOP_W-1:0] w_nxt_hop;
    logic             w_lost;
    logic             w_chan_set;
    logic [HOP_W-1:0] w_chan_out;
    logic             w_restart;
    logic             w_reply;

    assign w_nxt_hop = next_hop(r_hop, i_cfg.channel_count);
    assign w_lost    = (r_missed >= i_cfg.loss_threshold);

    // link state
    always_comb begin
        n_link = r_link;
        unique case (i_evt.mode)
            EVT_SCAN: n_link = LINK_SEARCH;
            EVT_PKT:  n_link = LINK_WAIT_ACK;
            EVT_TICK: begin
                unique case (r_link)
                    LINK_WAIT_ACK: n_link = LINK_OPERATE;
                    LINK_OPERATE:  n_link = w_lost ? LINK_SEARCH : LINK_OPERATE;
                    default:       n_link = r_link;
                endcase
            end
            default: n_link = r_link;
        endcase
    end

    // flags, counters and actions
    always_comb begin
        n_rx_on    = r_rx_on;
        n_reload   = r_reload;
        n_first    = r_first;
        n_got      = r_got;
        n_hop      = r_hop;
        n_missed   = r_missed;
        n_period   = r_period;
        w_chan_set = 1'b0;
        w_chan_out = r_hop;
        w_restart  = 1'b0;
        w_reply    = 1'b0;
        unique case (i_evt.mode)
            EVT_SCAN: begin
                n_period = i_cfg.search_period;
                n_rx_on  = 1'b1;
            end
            EVT_PKT: begin
                if (r_first) begin
                    n_rx_on    = 1'b0;
                    n_hop      = w_nxt_hop;
                    w_chan_set = 1'b1;
                    w_chan_out = w_nxt_hop;
                    n_first    = 1'b0;
                end
                n_got     = 1'b1;
                w_reply   = i_evt.payload_ok;
                w_restart = 1'b1;
                n_period  = i_cfg.ack_wait_period;
                n_missed  = '0;
            end
            EVT_TICK: begin
                w_restart = 1'b1;
                unique case (r_link)
                    LINK_SEARCH: begin
                        if (r_reload) begin
                            n_period = i_cfg.search_period;
                            n_reload = 1'b0;
                        end
                        n_rx_on = !r_rx_on;
                        if (!r_rx_on) begin
                            n_hop      = w_nxt_hop;
                            w_chan_set = 1'b1;
                            w_chan_out = w_nxt_hop;
                        end
                    end
                    LINK_WAIT_ACK: begin
                        n_rx_on  = 1'b0;
                        n_period = i_cfg.after_ack_period;
                        n_got    = 1'b1;
                    end
                    default: begin
                        if (w_lost) begin
                            // fall back: receiver and channel stay put
                            n_reload = 1'b1;
                            n_first  = 1'b1;
                        end else begin
                            n_period   = i_cfg.operate_period;
                            w_chan_set = 1'b1;
                            n_hop      = w_nxt_hop;
                            if (!r_got && (r_missed != LOSS_MAX)) begin
                                n_missed = r_missed + LOSS_W'(1);
                            end
                            n_rx_on = 1'b1;
                        end
                        n_got = 1'b0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link   <= LINK_SEARCH;
            r_rx_on  <= 1'b1;
            r_reload <= 1'b0;
            r_first  <= 1'b1;
            r_got    <= 1'b0;
            r_hop    <= '0;
            r_missed <= '0;
            r_period <= RST_SEARCH_PERIOD;
        end else if (i_go) begin
            r_link   <= n_link;
            r_rx_on  <= n_rx_on;
            r_reload <= n_reload;
            r_first  <= n_first;
            r_got    <= n_got;
            r_hop    <= n_hop;
            r_missed <= n_missed;
            r_period <= n_period;
        end
    end

    always_comb begin
        o_res.rx_enable     = n_rx_on;
        o_res.channel_index = w_chan_out;
        o_res.channel_set   = w_chan_set;
        o_res.timer_period  = n_period;
        o_res.timer_restart = w_restart;
        o_res.reply_sent    = w_reply;
        o_res.link_state    = n_link;
        o_res.loss_count    = n_missed;
    end

    `RSHC_ASSERT(a_pkt_sync, i_clk, i_rst_n, (i_go && i_evt.mode == EVT_PKT) |=> (r_link == LINK_WAIT_ACK && r_missed == '0 && !r_first), "packet did not sync link")
    `RSHC_ASSERT(a_search_on, i_clk, i_rst_n, (i_go && i_evt.mode == EVT_TICK && r_link == LINK_SEARCH && !r_rx_on) |=> (r_rx_on && $past(w_chan_set)), "search tick did not hop")
    `RSHC_ASSERT(a_loss_sat, i_clk, i_rst_n, (r_missed == LOSS_MAX) |=> (r_missed == LOSS_MAX || r_missed == '0), "loss count wrapped")
    `RSHC_ASSERT(a_idle_hold, i_clk, i_rst_n, !i_go |=> ($stable(r_link) && $stable(r_hop) && $stable(r_period)), "state moved without event")

endmodule

@@ rtl/rx_sync_hop_controller_unit.sv @@
// Channel   Dir  Word                                  Handshake
// i_evt     in   mode, payload_ok                      valid/ready
// o_res     out  rx_enable .. loss_count (8 fields)    valid/ready
// i_cfg_*   in   index 0..5, 24-bit data               write enable, no stall
//
// An event enters the input register; the link logic updates state and
// fills the result register, so a new word can enter every cycle unless a
// stalled result blocks it. Valid rises when the result register fills.
// Reset (synchronous, active low) empties both registers and loads the
// register defaults and the search state. A stalled result holds; the input
// register keeps taking words while the result register is free or drains.
`include "rx_sync_hop_controller_unit_assert.svh"

module rx_sync_hop_controller_unit import rshc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rshc_evt_if.sink              i_evt,
    rshc_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      w_cfg;
    t_evt_word r_in_word;
    logic      r_in_v;
    t_res_word r_res;
    t_res_word w_res;
    logic      r_out_v;
    logic      w_adv;       // result register can take a word
    logic      w_in_ready;
    logic      w_go;        // word in input register is processed

    rshc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    assign w_adv      = !r_out_v || o_res.ready;
    assign w_in_ready = !r_in_v || w_adv;
    assign w_go       = r_in_v && w_adv;

    assign i_evt.ready = w_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_ready) begin
            r_in_v <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_evt.valid) begin
            r_in_word.mode       <= i_evt.mode;
            r_in_word.payload_ok <= i_evt.payload_ok;
        end
    end

    rshc_link_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_go    (w_go),
        .i_evt   (r_in_word),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.rx_enable     = r_res.rx_enable;
    assign o_res.channel_index = r_res.channel_index;
    assign o_res.channel_set   = r_res.channel_set;
    assign o_res.timer_period  = r_res.timer_period;
    assign o_res.timer_restart = r_res.timer_restart;
    assign o_res.reply_sent    = r_res.reply_sent;
    assign o_res.link_state    = r_res.link_state;
    assign o_res.loss_count    = r_res.loss_count;

    `RSHC_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_v && !w_adv) |=> (r_in_v && $stable(r_in_word)), "pending event lost")
    `RSHC_ASSERT(a_go_fills, i_clk, i_rst_n, w_go |=> r_out_v, "processed event gave no result")
    `RSHC_ASSERT(a_res_hold, i_clk, i_rst_n, (r_out_v && !o_res.ready) |=> (r_out_v && $stable(r_res)), "stalled result changed")
    `RSHC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (!r_in_v && !r_out_v), "pipeline not empty after reset")

endmodule
